// File: rtl/midi_file_track_parser_defines.svh
// Assertion macros for the MIDI file track parser.
`ifndef MIDI_FILE_TRACK_PARSER_DEFINES_SVH
`define MIDI_FILE_TRACK_PARSER_DEFINES_SVH
`ifndef SYNTH
`define MFP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MFP_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MFP_ASSERT(label, clk, rst_n, prop, msg)
`define MFP_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// File: rtl/mfp_pkg.sv
// Shared types and constants for the MIDI file track parser.
package mfp_pkg;
	localparam logic [31:0] FILE_MAGIC  = 32'h4D546864;
	localparam logic [31:0] TRACK_MAGIC = 32'h4D54726B;
	localparam logic [7:0]  META_EOT    = 8'd47;

	typedef enum logic [3:0] {
		PH_HEADER, PH_TRACKHDR, PH_DELTA, PH_STATUS, PH_DATA1,
		PH_DATA2, PH_LEN, PH_PAYLOAD, PH_DONE, PH_ERROR
	} phase_t;

	typedef enum logic [2:0] {
		K_HEADER = 3'd0, K_SHORT = 3'd1, K_LONG = 3'd2,
		K_PAYLOAD = 3'd3, K_DONE = 3'd4, K_ERROR = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		E_FILE_MAGIC = 3'd0, E_FORMAT = 3'd1, E_HDR_LEN = 3'd2,
		E_TRACK_MAGIC = 3'd3, E_NO_STATUS = 3'd4, E_UNKNOWN = 3'd5
	} cause_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] tick;
		logic [15:0] track;
		logic [7:0]  status;
		logic [14:0] value1;
		logic [7:0]  value2;
		logic [31:0] length;
		logic [7:0]  payload_byte;
		cause_t      error_cause;
		logic [15:0] track_count;
		logic [15:0] ticks_per_quarter;
	} result_t;

	// results of one byte: up to two
	typedef struct packed {
		logic    n2;
		logic    n1;
		result_t r0;
		result_t r1;
	} step_out_t;
endpackage

// File: rtl/mfp_core.sv
// Parser state and per-byte decode; one byte per cycle while step is high, up to two results.
module mfp_core import mfp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  logic [7:0] data_byte,
	input  logic      start_of_file,
	output step_out_t res
);
	phase_t      phase_q, ph, ph_n;
	logic [3:0]  hpos_q, hpos, hpos_n;
	logic [31:0] asm_q, asm_c, asm_n;
	logic [15:0] ntr_q, ntr, ntr_n;
	logic [15:0] ctr_q, ctr, ctr_n;
	logic [31:0] clen_q, clen, clen_n;
	logic [31:0] cons_q, cons, cons_n;
	logic [31:0] tick_q, tick, tick_n;
	logic [31:0] vacc_q, vacc, vacc_n, vnew;
	logic [7:0]  rs_q, rs, rs_n;
	logic [7:0]  hd_q, hd, hd_n;
	logic [7:0]  mt_q, mt, mt_n;
	logic [31:0] prem_q, prem, prem_n;
	logic [31:0] prem_dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hpos_q <= '0; asm_q <= '0; ntr_q <= '0; ctr_q <= '0;
			clen_q <= '0; cons_q <= '0; tick_q <= '0; vacc_q <= '0;
			rs_q <= '0; hd_q <= '0; mt_q <= '0; prem_q <= '0;
		end else if (step) begin
			phase_q <= ph_n;
			hpos_q <= hpos_n; asm_q <= asm_n; ntr_q <= ntr_n; ctr_q <= ctr_n;
			clen_q <= clen_n; cons_q <= cons_n; tick_q <= tick_n; vacc_q <= vacc_n;
			rs_q <= rs_n; hd_q <= hd_n; mt_q <= mt_n; prem_q <= prem_n;
		end
	end

	function automatic result_t mk(kind_t k, logic [31:0] t, logic [15:0] tr,
			logic [15:0] tc);
		result_t r;
		r = '0;
		r.kind = k; r.tick = t; r.track = tr; r.track_count = tc;
		return r;
	endfunction

	always_comb begin
		logic ends_evt;
		logic end_trk;
		logic [3:0] pos;
		logic [15:0] ctr_inc;
		result_t r;
		// start_of_file acts as a reset before the byte
		if (start_of_file) begin
			ph = PH_HEADER; hpos = '0; asm_c = '0; ntr = '0; ctr = '0;
			clen = '0; cons = '0; tick = '0; vacc = '0; rs = '0; hd = '0;
			mt = '0; prem = '0;
		end else begin
			ph = phase_q; hpos = hpos_q; asm_c = asm_q; ntr = ntr_q; ctr = ctr_q;
			clen = clen_q; cons = cons_q; tick = tick_q; vacc = vacc_q; rs = rs_q;
			hd = hd_q; mt = mt_q; prem = prem_q;
		end
		ph_n = ph; hpos_n = hpos; asm_n = asm_c; ntr_n = ntr; ctr_n = ctr;
		clen_n = clen; cons_n = cons; tick_n = tick; vacc_n = vacc; rs_n = rs;
		hd_n = hd; mt_n = mt; prem_n = prem;
		res = '0;
		ends_evt = 1'b0;
		end_trk = 1'b0;
		pos = hpos;
		vnew = {vacc[24:0], data_byte[6:0]};
		prem_dec = prem - 32'd1;
		ctr_inc = ctr + 16'd1;
		r = '0;

		if ((ph == PH_DELTA || ph == PH_STATUS || ph == PH_DATA1 || ph == PH_DATA2
				|| ph == PH_LEN || ph == PH_PAYLOAD) && cons != '1)
			cons_n = cons + 32'd1;

		unique case (ph)
			PH_HEADER, PH_TRACKHDR: begin
				asm_n = {asm_c[23:0], data_byte};
				hpos_n = pos + 4'd1;
				if (ph == PH_HEADER) begin
					if (pos == 4'd3 && asm_n != FILE_MAGIC) begin
						res.n1 = 1'b1;
						res.r0 = mk(K_ERROR, tick, ctr, ntr);
						res.r0.error_cause = E_FILE_MAGIC; ph_n = PH_ERROR;
					end else if (pos == 4'd7 && asm_n != 32'd6) begin
						res.n1 = 1'b1;
						res.r0 = mk(K_ERROR, tick, ctr, ntr);
						res.r0.error_cause = E_HDR_LEN; ph_n = PH_ERROR;
					end else if (pos == 4'd9 && asm_n[15:0] >= 16'd2) begin
						res.n1 = 1'b1;
						res.r0 = mk(K_ERROR, tick, ctr, ntr);
						res.r0.error_cause = E_FORMAT; ph_n = PH_ERROR;
					end else if (pos == 4'd11) begin
						ntr_n = asm_n[15:0];
					end else if (pos == 4'd13) begin
						ctr_n = '0;
						res.n1 = 1'b1;
						res.r0 = mk(K_HEADER, tick, 16'd0, ntr);
						res.r0.ticks_per_quarter = asm_n[15:0];
						if (ntr == '0) begin
							res.n2 = 1'b1;
							res.r1 = mk(K_DONE, tick, 16'd0, ntr);
							ph_n = PH_DONE;
						end else begin
							ph_n = PH_TRACKHDR; hpos_n = '0;
						end
					end
				end else begin
					if (pos == 4'd3 && asm_n != TRACK_MAGIC) begin
						res.n1 = 1'b1;
						res.r0 = mk(K_ERROR, tick, ctr, ntr);
						res.r0.error_cause = E_TRACK_MAGIC; ph_n = PH_ERROR;
					end else if (pos == 4'd7) begin
						clen_n = asm_n; cons_n = '0; tick_n = '0; rs_n = '0; vacc_n = '0;
						if (asm_n == '0) end_trk = 1'b1;
						else ph_n = PH_DELTA;
					end
				end
			end
			PH_DELTA: begin
				vacc_n = vnew;
				if (!data_byte[7]) begin
					tick_n = tick + vnew; vacc_n = '0; ph_n = PH_STATUS;
				end
			end
			PH_STATUS, PH_DATA1: begin
				if (ph == PH_STATUS && data_byte[7]) begin
					if (data_byte < 8'hF0 || data_byte == 8'hFF) begin
						rs_n = data_byte; ph_n = PH_DATA1;
					end else if (data_byte == 8'hF0 || data_byte == 8'hF7) begin
						rs_n = data_byte; mt_n = '0; ph_n = PH_LEN;
					end else begin
						res.n1 = 1'b1;
						res.r0 = mk(K_ERROR, tick, ctr, ntr);
						res.r0.error_cause = E_UNKNOWN; ph_n = PH_ERROR;
					end
				end else if (ph == PH_STATUS && rs == '0) begin
					res.n1 = 1'b1;
					res.r0 = mk(K_ERROR, tick, ctr, ntr);
					res.r0.error_cause = E_NO_STATUS; ph_n = PH_ERROR;
				end else if (ph == PH_DATA1 && rs == 8'hFF) begin
					mt_n = data_byte; ph_n = PH_LEN;
				end else if (rs >= 8'hC0 && rs < 8'hE0) begin
					res.n1 = 1'b1;
					res.r0 = mk(K_SHORT, tick, ctr, ntr);
					res.r0.status = rs; res.r0.value1 = {7'd0, data_byte};
					ends_evt = 1'b1;
				end else begin
					hd_n = data_byte; ph_n = PH_DATA2;
				end
			end
			PH_DATA2: begin
				res.n1 = 1'b1;
				res.r0 = mk(K_SHORT, tick, ctr, ntr);
				res.r0.status = rs;
				if (rs >= 8'hE0 && rs < 8'hF0) res.r0.value1 = {data_byte, hd[6:0]};
				else begin
					res.r0.value1 = {7'd0, hd}; res.r0.value2 = data_byte;
				end
				ends_evt = 1'b1;
			end
			PH_LEN: begin
				vacc_n = vnew;
				if (!data_byte[7]) begin
					prem_n = vnew; vacc_n = '0;
					if (!(rs == 8'hFF && mt == META_EOT)) begin
						res.n1 = 1'b1;
						res.r0 = mk(K_LONG, tick, ctr, ntr);
						res.r0.status = rs; res.r0.value2 = mt; res.r0.length = vnew;
					end
					if (vnew == '0) ends_evt = 1'b1;
					else ph_n = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (!(rs == 8'hFF && mt == META_EOT)) begin
					res.n1 = 1'b1;
					res.r0 = mk(K_PAYLOAD, tick, ctr, ntr);
					res.r0.status = rs; res.r0.value2 = mt; res.r0.payload_byte = data_byte;
				end
				prem_n = prem_dec;
				if (prem_dec == '0) ends_evt = 1'b1;
			end
			PH_DONE, PH_ERROR: ;
			default: ;
		endcase

		if (ends_evt) begin
			if (rs >= 8'hF0 && (ph == PH_LEN || ph == PH_PAYLOAD)) rs_n = '0;
			if (cons_n >= clen) end_trk = 1'b1;
			else ph_n = PH_DELTA;
		end
		if (end_trk) begin
			ctr_n = ctr_inc;
			if (ctr_inc >= ntr) begin
				r = mk(K_DONE, tick_n, ctr_inc, ntr);
				if (res.n1) begin
					res.n2 = 1'b1; res.r1 = r;
				end else begin
					res.n1 = 1'b1; res.r0 = r;
				end
				ph_n = PH_DONE;
			end else begin
				ph_n = PH_TRACKHDR; hpos_n = '0;
			end
		end
	end
endmodule

// File: rtl/mfp_out_queue.sv
// Result queue: holds up to four results, drains one per cycle while ready is high.
module mfp_out_queue import mfp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  step_out_t res,
	output logic      room,
	output logic      valid,
	input  logic      ready,
	output result_t   head,
	output logic      head_last
);
	result_t    mem_q [4];
	logic [3:0] last_q;
	logic [1:0] rd_q, wr_q;
	logic [2:0] cnt_q;
	logic [1:0] nin;
	logic       pop;

	assign nin   = push ? ({1'b0, res.n1} + {1'b0, res.n2}) : 2'd0;
	assign pop   = valid && ready;
	assign valid = cnt_q != 3'd0;
	assign room  = cnt_q <= 3'd2 || (cnt_q == 3'd3 && pop);
	assign head  = mem_q[rd_q];
	assign head_last = last_q[rd_q];

	always_ff @(posedge clk) begin
		if (nin != 2'd0) mem_q[wr_q] <= res.r0;
		if (nin == 2'd2) mem_q[wr_q + 2'd1] <= res.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0; wr_q <= '0; cnt_q <= '0; last_q <= '0;
		end else begin
			if (nin == 2'd1) last_q[wr_q] <= 1'b1;
			if (nin == 2'd2) begin
				last_q[wr_q] <= 1'b0; last_q[wr_q + 2'd1] <= 1'b1;
			end
			wr_q <= wr_q + nin;
			rd_q <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, nin} - {2'b0, pop};
		end
	end
endmodule

// File: rtl/midi_file_track_parser.sv
// Top level of the MIDI file track parser.
// Feed the file a byte per item on data_byte with start_of_file high on the
// first byte of each file. Results leave on the output channel: header ok,
// channel events, sysex/meta starts, payload bytes, done, or an error.
// last marks the final result that one input byte caused.
// Each input byte is decoded in the cycle it is accepted, and its results are
// registered in the result queue.
// Throughput is one byte per cycle while the output side takes results; a
// byte can cause two results, which the four-entry queue absorbs, and
// in_ready drops only when the queue cannot take two more.
// After an error the parser ignores bytes until the next start_of_file;
// after done, further bytes give no results.
// Reset clears the parser to wait for a file header and empties the queue.
// A stalled receiver holds the head result steady until it is taken.
`include "midi_file_track_parser_defines.svh"
module midi_file_track_parser import mfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        start_of_file,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic        last,
	output logic [31:0] tick,
	output logic [15:0] track,
	output logic [7:0]  status,
	output logic [14:0] value1,
	output logic [7:0]  value2,
	output logic [31:0] length,
	output logic [7:0]  payload_byte,
	output logic [2:0]  error_cause,
	output logic [15:0] track_count,
	output logic [15:0] ticks_per_quarter
);
	step_out_t res;
	result_t   head;
	logic      step;

	assign step = in_valid && in_ready;

	mfp_core u_core (
		.clk, .arst_n, .step, .data_byte, .start_of_file, .res
	);

	mfp_out_queue u_queue (
		.clk, .arst_n, .push(step), .res, .room(in_ready),
		.valid(out_valid), .ready(out_ready), .head, .head_last(last)
	);

	assign kind = head.kind;
	assign tick = head.tick;
	assign track = head.track;
	assign status = head.status;
	assign value1 = head.value1;
	assign value2 = head.value2;
	assign length = head.length;
	assign payload_byte = head.payload_byte;
	assign error_cause = head.error_cause;
	assign track_count = head.track_count;
	assign ticks_per_quarter = head.ticks_per_quarter;

	`MFP_NEVER(a_two_needs_one, clk, arst_n, step && res.n2 && !res.n1, "second result without first")
	`MFP_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
	`MFP_NEVER(a_kind_range, clk, arst_n, out_valid && kind > 3'd5, "bad result kind")
endmodule

// File: tb/midi_file_track_parser_test.sv
// Self-checking testbench for midi_file_track_parser: byte stream in, parsed events checked.
module midi_file_track_parser_test;
	import mfp_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int ITEM_TARGET = 1550;

	typedef struct {
		logic [7:0] d;
		logic       s;
		bit         typed;
		kind_t      k;
		cause_t     c;
	} byte_item_t;

	typedef struct packed {
		logic    last;
		result_t r;
	} parsed_t;

	logic        clk = 0;
	logic        arst_n;
	logic        in_valid, in_ready, out_valid, out_ready;
	logic [7:0]  data_byte;
	logic        start_of_file;
	logic [2:0]  kind, error_cause;
	logic        last;
	logic [31:0] tick, length;
	logic [15:0] track, track_count, ticks_per_quarter;
	logic [7:0]  status, value2, payload_byte;
	logic [14:0] value1;

	midi_file_track_parser u_dut (.*);

	always #5 clk = ~clk;

	// parser mirror
	phase_t      ph;
	logic [3:0]  hdr_pos;
	logic [31:0] asm_word, chunk_len, chunk_used, abs_tick, vl_acc, pay_left;
	logic [15:0] n_tracks, cur_track;
	logic [7:0]  run_st, held_d, held_type;
	result_t     step_res [2];
	int          step_n;
	int          bytes_in = 0;

	parsed_t     events_due [$];
	byte_item_t  sent_q [$];
	byte_item_t  stim_q [$];
	logic [7:0]  chunk_body [$];
	int          errors = 0;
	int          cycles = 0;
	int          tx_idle = 36, rx_idle = 88;
	logic        hold_off;

	byte_item_t directed_rows [26] = '{
		'{8'h4D, 1'b1, 1'b0, K_HEADER, E_FILE_MAGIC},
		'{8'h54, 1'b0, 1'b0, K_HEADER, E_FILE_MAGIC},
		'{8'h68, 1'b0, 1'b0, K_HEADER, E_FILE_MAGIC},
		'{8'h58, 1'b0, 1'b1, K_ERROR,  E_FILE_MAGIC},
		// zero tracks: header ok and done on the last header byte
		'{8'h4D, 1'b1, 1'b0, K_HEADER, E_FILE_MAGIC},
		'{8'h54, 1'b0, 1'b0, K_HEADER, E_FILE_MAGIC},
		'{8'h68, 1'b0, 1'b0, K_HEADER, E_FILE_MAGIC},
		'{8'h64, 1'b0, 1'b0, K_HEADER, E_FILE_MAGIC},
		'{8'h00, 1'b0, 1'b0, K_HEADER, E_FILE_MAGIC},
		'{8'h00, 1'b0, 1'b0, K_HEADER, E_FILE_MAGIC},
		'{8'h00, 1'b0, 1'b0, K_HEADER, E_FILE_MAGIC},
		'{8'h06, 1'b0, 1'b0, K_HEADER, E_FILE_MAGIC},
		'{8'h00, 1'b0, 1'b0, K_HEADER, E_FILE_MAGIC},
		'{8'h01, 1'b0, 1'b0, K_HEADER, E_FILE_MAGIC},
		'{8'h00, 1'b0, 1'b0, K_HEADER, E_FILE_MAGIC},
		'{8'h00, 1'b0, 1'b0, K_HEADER, E_FILE_MAGIC},
		'{8'hFF, 1'b0, 1'b0, K_HEADER, E_FILE_MAGIC},
		'{8'hFF, 1'b0, 1'b1, K_HEADER, E_FILE_MAGIC},
		// bad header length
		'{8'h4D, 1'b1, 1'b0, K_HEADER, E_FILE_MAGIC},
		'{8'h54, 1'b0, 1'b0, K_HEADER, E_FILE_MAGIC},
		'{8'h68, 1'b0, 1'b0, K_HEADER, E_FILE_MAGIC},
		'{8'h64, 1'b0, 1'b0, K_HEADER, E_FILE_MAGIC},
		'{8'h00, 1'b0, 1'b0, K_HEADER, E_FILE_MAGIC},
		'{8'h00, 1'b0, 1'b0, K_HEADER, E_FILE_MAGIC},
		'{8'h00, 1'b0, 1'b0, K_HEADER, E_FILE_MAGIC},
		'{8'h07, 1'b0, 1'b1, K_ERROR,  E_HDR_LEN}
	};

	function automatic void post(kind_t k, logic [7:0] st, logic [14:0] v1, logic [7:0] v2,
			logic [31:0] ln, logic [7:0] pb, cause_t c, logic [15:0] tpq);
		result_t r;
		if (step_n >= 2) return;
		r.kind = k;
		r.tick = abs_tick;
		r.track = cur_track;
		r.status = st;
		r.value1 = v1;
		r.value2 = v2;
		r.length = ln;
		r.payload_byte = pb;
		r.error_cause = c;
		r.track_count = n_tracks;
		r.ticks_per_quarter = tpq;
		step_res[step_n] = r;
		step_n++;
	endfunction

	function automatic void clear_parser();
		ph = PH_HEADER;
		hdr_pos = 0;
		asm_word = 0;
		n_tracks = 0;
		cur_track = 0;
		chunk_len = 0;
		chunk_used = 0;
		abs_tick = 0;
		vl_acc = 0;
		run_st = 0;
		held_d = 0;
		held_type = 0;
		pay_left = 0;
	endfunction

	function automatic void abort_file(cause_t c);
		post(K_ERROR, 0, 0, 0, 0, 0, c, 0);
		ph = PH_ERROR;
	endfunction

	function automatic void close_track();
		cur_track++;
		if (cur_track >= n_tracks) begin
			post(K_DONE, 0, 0, 0, 0, 0, E_FILE_MAGIC, 0);
			ph = PH_DONE;
		end else begin
			ph = PH_TRACKHDR;
			hdr_pos = 0;
		end
	endfunction

	function automatic void close_event();
		if (run_st >= 8'hF0) run_st = 0;
		if (chunk_used >= chunk_len) close_track();
		else ph = PH_DELTA;
	endfunction

	function automatic void first_data(logic [7:0] b);
		if (run_st >= 8'hC0 && run_st < 8'hE0) begin
			post(K_SHORT, run_st, {7'd0, b}, 0, 0, 0, E_FILE_MAGIC, 0);
			close_event();
		end else begin
			held_d = b;
			ph = PH_DATA2;
		end
	endfunction

	function automatic bit varlen_done(logic [7:0] b);
		vl_acc = {vl_acc[24:0], b[6:0]};
		return !b[7];
	endfunction

	function automatic bit is_end_of_track();
		return run_st == 8'hFF && held_type == META_EOT;
	endfunction

	function automatic void parse_byte(logic [7:0] b, logic sof);
		logic [3:0] pos;
		step_n = 0;
		if (sof) clear_parser();
		bytes_in++;
		if (ph >= PH_DELTA && ph <= PH_PAYLOAD && chunk_used != 32'hFFFFFFFF) chunk_used++;
		case (ph)
			PH_HEADER: begin
				asm_word = {asm_word[23:0], b};
				pos = hdr_pos;
				hdr_pos = pos + 4'd1;
				if (pos == 3) begin
					if (asm_word != FILE_MAGIC) abort_file(E_FILE_MAGIC);
				end else if (pos == 7) begin
					if (asm_word != 6) abort_file(E_HDR_LEN);
				end else if (pos == 9) begin
					if (asm_word[15:0] >= 2) abort_file(E_FORMAT);
				end else if (pos == 11) begin
					n_tracks = asm_word[15:0];
				end else if (pos == 13) begin
					cur_track = 0;
					post(K_HEADER, 0, 0, 0, 0, 0, E_FILE_MAGIC, asm_word[15:0]);
					if (n_tracks == 0) begin
						post(K_DONE, 0, 0, 0, 0, 0, E_FILE_MAGIC, 0);
						ph = PH_DONE;
					end else begin
						ph = PH_TRACKHDR;
						hdr_pos = 0;
					end
				end
			end
			PH_TRACKHDR: begin
				asm_word = {asm_word[23:0], b};
				pos = hdr_pos;
				hdr_pos = pos + 4'd1;
				if (pos == 3) begin
					if (asm_word != TRACK_MAGIC) abort_file(E_TRACK_MAGIC);
				end else if (pos == 7) begin
					chunk_len = asm_word;
					chunk_used = 0;
					abs_tick = 0;
					run_st = 0;
					vl_acc = 0;
					if (chunk_len == 0) close_track();
					else ph = PH_DELTA;
				end
			end
			PH_DELTA: begin
				if (varlen_done(b)) begin
					abs_tick = abs_tick + vl_acc;
					vl_acc = 0;
					ph = PH_STATUS;
				end
			end
			PH_STATUS: begin
				if (b[7]) begin
					if (b < 8'hF0 || b == 8'hFF) begin
						run_st = b;
						ph = PH_DATA1;
					end else if (b == 8'hF0 || b == 8'hF7) begin
						run_st = b;
						held_type = 0;
						ph = PH_LEN;
					end else begin
						abort_file(E_UNKNOWN);
					end
				end else if (run_st == 0) begin
					abort_file(E_NO_STATUS);
				end else begin
					first_data(b);
				end
			end
			PH_DATA1: begin
				if (run_st == 8'hFF) begin
					held_type = b;
					ph = PH_LEN;
				end else begin
					first_data(b);
				end
			end
			PH_DATA2: begin
				if (run_st >= 8'hE0 && run_st < 8'hF0)
					post(K_SHORT, run_st, {b, held_d[6:0]}, 0, 0, 0, E_FILE_MAGIC, 0);
				else
					post(K_SHORT, run_st, {7'd0, held_d}, b, 0, 0, E_FILE_MAGIC, 0);
				close_event();
			end
			PH_LEN: begin
				if (varlen_done(b)) begin
					pay_left = vl_acc;
					vl_acc = 0;
					if (!is_end_of_track())
						post(K_LONG, run_st, 0, held_type, pay_left, 0, E_FILE_MAGIC, 0);
					if (pay_left == 0) close_event();
					else ph = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (!is_end_of_track())
					post(K_PAYLOAD, run_st, 0, held_type, 0, b, E_FILE_MAGIC, 0);
				pay_left = pay_left - 1;
				if (pay_left == 0) close_event();
			end
			default: ;
		endcase
	endfunction

	// ---------------- stimulus generation ----------------
	function automatic void put(logic [7:0] d, logic s);
		stim_q.insert(stim_q.size(), '{d, s, 1'b0, K_HEADER, E_FILE_MAGIC});
	endfunction

	function automatic void add_body(logic [7:0] b);
		chunk_body.insert(chunk_body.size(), b);
	endfunction

	function automatic void put_word(logic [31:0] w, int nb, logic s);
		for (int i = nb - 1; i >= 0; i--) put(w[8*i +: 8], (i == nb - 1) ? s : 1'b0);
	endfunction

	function automatic void body_varlen(logic [31:0] v, int nb);
		logic [7:0] g;
		for (int k = nb - 1; k >= 0; k--) begin
			g = {(k != 0), 7'((v >> (7 * k)) & 32'h7F)};
			add_body(g);
		end
	endfunction

	function automatic void body_long(int len);
		body_varlen(len, ($urandom_range(9) == 0) ? 2 : 1);
		repeat (len) add_body(8'($urandom_range(0, 255)));
	endfunction

	function automatic void gen_file();
		int ntr, nev, r;
		logic [7:0] rs, st;
		logic [31:0] w;
		ntr = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 3);
		w = FILE_MAGIC;
		if ($urandom_range(32) == 0) w ^= 32'd1 << $urandom_range(31);
		put_word(w, 4, 1'b1);
		put_word(($urandom_range(24) == 0) ? $urandom : 32'd6, 4, 1'b0);
		put_word(($urandom_range(24) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 1),
			2, 1'b0);
		put_word(ntr, 2, 1'b0);
		put_word($urandom_range(0, 65535), 2, 1'b0);
		for (int t = 0; t < ntr; t++) begin
			chunk_body.delete();
			rs = 0;
			nev = $urandom_range(0, 6);
			for (int e = 0; e < nev; e++) begin
				if ($urandom_range(3) == 0) body_varlen($urandom, $urandom_range(2, 5));
				else body_varlen($urandom_range(0, 127), 1);
				r = $urandom_range(99);
				if (r < 45) begin
					if (rs != 0 && $urandom_range(1)) begin
						st = rs;
						add_body(8'($urandom_range(0, 127)));
					end else begin
						st = 8'($urandom_range(8'h80, 8'hEF));
						add_body(st);
						add_body(8'($urandom_range(0, 255)));
					end
					rs = st;
					if (st < 8'hC0 || st >= 8'hE0) add_body(8'($urandom_range(0, 255)));
				end else if (r < 60) begin
					add_body($urandom_range(1) ? 8'hF0 : 8'hF7);
					body_long($urandom_range(0, 4));
					rs = 0;
				end else if (r < 88) begin
					add_body(8'hFF);
					add_body(($urandom_range(4) == 0) ? META_EOT : 8'($urandom));
					body_long($urandom_range(0, 4));
					rs = 0;
				end else if (r < 94) begin
					st = 8'($urandom_range(8'hF1, 8'hFE));
					add_body((st == 8'hF7) ? 8'hF1 : st);
				end else begin
					// data byte where a status is due
					add_body(8'($urandom_range(0, 127)));
				end
			end
			if ($urandom_range(4) != 0) begin
				add_body(8'h00);
				add_body(8'hFF);
				add_body(META_EOT);
				add_body(8'h00);
			end
			w = TRACK_MAGIC;
			if ($urandom_range(32) == 0) w ^= 32'd1 << $urandom_range(31);
			put_word(w, 4, 1'b0);
			if ($urandom_range(6) == 0) put_word($urandom_range(0, chunk_body.size() + 3), 4, 1'b0);
			else put_word(chunk_body.size(), 4, 1'b0);
			foreach (chunk_body[i]) put(chunk_body[i], 1'b0);
		end
		if ($urandom_range(19) == 0)
			repeat ($urandom_range(1, 4)) put(8'($urandom_range(0, 255)), 1'b0);
	endfunction

	task automatic send(byte_item_t it);
		while ($urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= it.d;
		start_of_file <= it.s;
		sent_q.insert(sent_q.size(), it);
		do @(posedge clk); while (!in_ready);
	endtask

	// ---------------- monitors ----------------
	always @(posedge clk) begin
		out_ready <= !hold_off && ($urandom_range(99) >= rx_idle);
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		byte_item_t row;
		result_t r;
		parsed_t pe;
		if (arst_n && in_valid && in_ready) begin
			row = sent_q.pop_front();
			parse_byte(data_byte, start_of_file);
			for (int i = 0; i < step_n; i++) begin
				r = step_res[i];
				if (row.typed && i == 0) begin
					r.kind = row.k;
					r.error_cause = row.c;
				end
				pe.last = (i == step_n - 1);
				pe.r = r;
				events_due.insert(events_due.size(), pe);
			end
		end
	end

	always @(posedge clk) begin
		parsed_t e;
		bit bad;
		if (arst_n && out_valid && out_ready) begin
			if (events_due.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result: kind %0d tick %0h", kind, tick);
			end else begin
				e = events_due.pop_front();
				bad = last !== e.last || kind !== e.r.kind || tick !== e.r.tick
					|| track !== e.r.track || status !== e.r.status
					|| value1 !== e.r.value1 || value2 !== e.r.value2
					|| length !== e.r.length || payload_byte !== e.r.payload_byte
					|| error_cause !== e.r.error_cause || track_count !== e.r.track_count
					|| ticks_per_quarter !== e.r.ticks_per_quarter;
				if (bad) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch exp: last %0d kind %0d tick %h trk %0d st %h v1 %h v2 %h",
							e.last, e.r.kind, e.r.tick, e.r.track, e.r.status, e.r.value1,
							e.r.value2);
						$display("  len %h pb %h cause %0d cnt %0d tpq %0d", e.r.length,
							e.r.payload_byte, e.r.error_cause, e.r.track_count,
							e.r.ticks_per_quarter);
						$display("mismatch got: last %0d kind %0d tick %h trk %0d st %h v1 %h v2 %h",
							last, kind, tick, track, status, value1, value2);
						$display("  len %h pb %h cause %0d cnt %0d tpq %0d", length,
							payload_byte, error_cause, track_count, ticks_per_quarter);
					end
				end
			end
		end
	end

	initial begin
		bit pressed;
		pressed = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		start_of_file = 1'b0;
		out_ready = 1'b0;
		hold_off = 1'b0;
		clear_parser();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i]) send(directed_rows[i]);
		while (bytes_in < ITEM_TARGET) begin
			if (bytes_in >= 2 * ITEM_TARGET / 3) begin
				tx_idle = 0;
				rx_idle = 0;
				if (!pressed) begin
					pressed = 1;
					// long receiver stall with the sender still pushing
					fork
						begin
							hold_off <= 1'b1;
							repeat (400) @(posedge clk);
							hold_off <= 1'b0;
						end
					join_none
				end
			end else if (bytes_in >= ITEM_TARGET / 3) begin
				tx_idle = 88;
				rx_idle = 36;
			end
			gen_file();
			while (stim_q.size() != 0) send(stim_q.pop_front());
		end
		in_valid <= 1'b0;
		while (events_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
